### src/vertex_normal_accumulator_macros.svh
// assertion macros for the vertex normal accumulator
`ifndef VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define VNA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vna check failed");

// next-cycle implication, disabled while in reset
`define VNA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vna check failed");

`endif

### src/vna_pkg.sv
// shared types and constants of the vertex normal accumulator
package vna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int IDX_W        = 10;
  localparam int COORD_W      = 16;
  localparam int POS_W        = 3 * COORD_W;
  localparam int ACC_W        = 26;
  localparam int ACC_WORD_W   = 3 * ACC_W;
  localparam int VEC_W        = 36;
  localparam int NRM_W        = 16;
  localparam int ONE_Q14      = 16384;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_TRI    = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                operation;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [IDX_W-1:0]          corner_a;
    logic [IDX_W-1:0]          corner_b;
    logic [IDX_W-1:0]          corner_c;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        normal_vertex;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                    zero_normal;
  } out_item_t;

  // request to the unit-length scaler
  typedef struct packed {
    logic                    start;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [VEC_W-1:0] vz;
  } unit_req_t;

  // answer of the unit-length scaler, held until the next start
  typedef struct packed {
    logic                    done;
    logic                    zero;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } unit_rsp_t;

endpackage

### src/vertex_normal_accumulator.sv
// top level of the vertex normal accumulator
`include "vertex_normal_accumulator_macros.svh"

// smooth vertex normals by averaging unit face normals. an item is taken at
// a clock edge with start high and busy low. a load (q8.8 position) is
// written in the accept cycle and clears that vertex's accumulator; busy
// stays low. a triangle reads its three corners from the position ram,
// forms the cross product with one shared 17x17 multiplier, scales it to
// unit length in the iterative scaler and then read-modify-writes the three
// accumulators one corner at a time. a read fetches the accumulator, scales
// it and shows one result with out_valid high for exactly one cycle; the
// receiver cannot stall it. the scaler sets most of the latency, which
// grows with its normalizing shifts. after reset the block sweeps the
// accumulator ram to zero, one entry a cycle through all 1024 entries,
// with busy high.
module vertex_normal_accumulator import vna_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_TRA   = 4'd2;
  localparam logic [3:0] S_TRB   = 4'd3;
  localparam logic [3:0] S_TRC   = 4'd4;
  localparam logic [3:0] S_TCAP  = 4'd5;
  localparam logic [3:0] S_CROSS = 4'd6;
  localparam logic [3:0] S_TWAIT = 4'd7;
  localparam logic [3:0] S_ACRD  = 4'd8;
  localparam logic [3:0] S_ACWR  = 4'd9;
  localparam logic [3:0] S_RRD   = 4'd10;
  localparam logic [3:0] S_RDAT  = 4'd11;
  localparam logic [3:0] S_RWAIT = 4'd12;

  localparam int E_W = COORD_W + 1;
  localparam int P_W = 2 * E_W;

  // control state
  logic [3:0]        state_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [2:0]        xcnt_r;
  logic [1:0]        k_r;
  logic              ustart_r;
  logic              out_valid_r;

  // payload
  logic [ADDR_W-1:0]     crn_r [3];
  logic [IDX_W-1:0]      rv_r;
  logic [POS_W-1:0]      pa_r;
  logic [POS_W-1:0]      pb_r;
  logic signed [E_W-1:0] e1x_r, e1y_r, e1z_r;
  logic signed [E_W-1:0] e2x_r, e2y_r, e2z_r;
  logic signed [P_W-1:0] prod_r;
  logic signed [VEC_W-1:0] cr_r [3];
  out_item_t             out_data_r;

  // ram ports
  logic                  pos_we;
  logic [ADDR_W-1:0]     pos_waddr;
  logic [POS_W-1:0]      pos_wdata;
  logic [ADDR_W-1:0]     pos_raddr;
  logic [POS_W-1:0]      pos_rdata;
  logic                  acc_we;
  logic [ADDR_W-1:0]     acc_waddr;
  logic [ACC_WORD_W-1:0] acc_wdata;
  logic [ADDR_W-1:0]     acc_raddr;
  logic [ACC_WORD_W-1:0] acc_rdata;

  unit_req_t u_req;
  unit_rsp_t u_rsp;

  logic                  accept;
  logic signed [E_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  logic signed [E_W-1:0] mul_a, mul_b;
  logic signed [P_W-1:0] prod_w;

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < MAX_VERTICES;
  endfunction

  // saturate to the accumulator range
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic signed [NRM_W-1:0] d);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'($signed(acc)) + (ACC_W+1)'(d);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  assign busy   = state_r != S_IDLE;
  assign accept = start && !busy;

  // corner positions, sign-extended for the edge subtraction
  assign ax = E_W'($signed(pa_r[POS_W-1 -: COORD_W]));
  assign ay = E_W'($signed(pa_r[2*COORD_W-1 -: COORD_W]));
  assign az = E_W'($signed(pa_r[COORD_W-1:0]));
  assign bx = E_W'($signed(pb_r[POS_W-1 -: COORD_W]));
  assign by = E_W'($signed(pb_r[2*COORD_W-1 -: COORD_W]));
  assign bz = E_W'($signed(pb_r[COORD_W-1:0]));
  assign cx = E_W'($signed(pos_rdata[POS_W-1 -: COORD_W]));
  assign cy = E_W'($signed(pos_rdata[2*COORD_W-1 -: COORD_W]));
  assign cz = E_W'($signed(pos_rdata[COORD_W-1:0]));

  // operand order for the six cross product terms
  always_comb begin
    case (xcnt_r)
      3'd0:    begin mul_a = e1y_r; mul_b = e2z_r; end
      3'd1:    begin mul_a = e1z_r; mul_b = e2y_r; end
      3'd2:    begin mul_a = e1z_r; mul_b = e2x_r; end
      3'd3:    begin mul_a = e1x_r; mul_b = e2z_r; end
      3'd4:    begin mul_a = e1x_r; mul_b = e2y_r; end
      3'd5:    begin mul_a = e1y_r; mul_b = e2x_r; end
      default: begin mul_a = e1x_r; mul_b = e2x_r; end
    endcase
  end

  assign prod_w = mul_a * mul_b;

  // ram port steering
  always_comb begin
    pos_we    = accept && (in_data.operation == OP_LOAD) && in_range(in_data.vertex_index);
    pos_waddr = ADDR_W'(in_data.vertex_index);
    pos_wdata = {in_data.pos_x, in_data.pos_y, in_data.pos_z};

    case (state_r)
      S_TRB:   pos_raddr = crn_r[1];
      S_TRC:   pos_raddr = crn_r[2];
      default: pos_raddr = crn_r[0];
    endcase

    acc_we    = 1'b0;
    acc_waddr = crn_r[k_r];
    acc_wdata = '0;
    if (state_r == S_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_cnt_r;
    end else if (pos_we) begin
      // a load also clears the vertex's sums
      acc_we    = 1'b1;
      acc_waddr = ADDR_W'(in_data.vertex_index);
    end else if (state_r == S_ACWR) begin
      acc_we    = 1'b1;
      acc_wdata = {sat_add(acc_rdata[ACC_WORD_W-1 -: ACC_W], u_rsp.nx),
                   sat_add(acc_rdata[2*ACC_W-1 -: ACC_W], u_rsp.ny),
                   sat_add(acc_rdata[ACC_W-1:0], u_rsp.nz)};
    end

    acc_raddr = (state_r == S_RRD) ? ADDR_W'(rv_r) : crn_r[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      ustart_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ustart_r    <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
          if (clr_cnt_r == ADDR_W'(MAX_VERTICES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            unique case (in_data.operation)
              OP_TRI: begin
                // a triangle with a corner out of range is dropped
                if (in_range(in_data.corner_a) && in_range(in_data.corner_b) &&
                    in_range(in_data.corner_c)) begin
                  crn_r[0] <= ADDR_W'(in_data.corner_a);
                  crn_r[1] <= ADDR_W'(in_data.corner_b);
                  crn_r[2] <= ADDR_W'(in_data.corner_c);
                  state_r  <= S_TRA;
                end
              end
              OP_READ: begin
                rv_r    <= in_data.vertex_index;
                state_r <= S_RRD;
              end
              default: ;
            endcase
          end
        end
        S_TRA: state_r <= S_TRB;
        S_TRB: begin
          pa_r    <= pos_rdata;
          state_r <= S_TRC;
        end
        S_TRC: begin
          pb_r    <= pos_rdata;
          state_r <= S_TCAP;
        end
        S_TCAP: begin
          // edges b - a and c - a
          e1x_r   <= bx - ax;
          e1y_r   <= by - ay;
          e1z_r   <= bz - az;
          e2x_r   <= cx - ax;
          e2y_r   <= cy - ay;
          e2z_r   <= cz - az;
          xcnt_r  <= '0;
          state_r <= S_CROSS;
        end
        S_CROSS: begin
          xcnt_r <= xcnt_r + 3'd1;
          if (xcnt_r != 3'd6) begin
            prod_r <= prod_w;
          end
          // product of the previous cycle lands in its component
          case (xcnt_r)
            3'd1:    cr_r[0] <= VEC_W'(prod_r);
            3'd2:    cr_r[0] <= cr_r[0] - VEC_W'(prod_r);
            3'd3:    cr_r[1] <= VEC_W'(prod_r);
            3'd4:    cr_r[1] <= cr_r[1] - VEC_W'(prod_r);
            3'd5:    cr_r[2] <= VEC_W'(prod_r);
            3'd6:    cr_r[2] <= cr_r[2] - VEC_W'(prod_r);
            default: ;
          endcase
          if (xcnt_r == 3'd6) begin
            ustart_r <= 1'b1;
            state_r  <= S_TWAIT;
          end
        end
        S_TWAIT: begin
          if (u_rsp.done) begin
            // degenerate face adds nothing
            if (u_rsp.zero) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= '0;
              state_r <= S_ACRD;
            end
          end
        end
        S_ACRD: state_r <= S_ACWR;
        S_ACWR: begin
          // corners are done strictly one after another, so repeated
          // corners see each other's sums
          if (k_r == 2'd2) begin
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_ACRD;
          end
        end
        S_RRD: begin
          if (in_range(rv_r)) begin
            state_r <= S_RDAT;
          end else begin
            out_valid_r                <= 1'b1;
            out_data_r.normal_vertex   <= rv_r;
            out_data_r.normal_x        <= '0;
            out_data_r.normal_y        <= '0;
            out_data_r.normal_z        <= '0;
            out_data_r.zero_normal     <= 1'b1;
            state_r                    <= S_IDLE;
          end
        end
        S_RDAT: begin
          cr_r[0]  <= VEC_W'($signed(acc_rdata[ACC_WORD_W-1 -: ACC_W]));
          cr_r[1]  <= VEC_W'($signed(acc_rdata[2*ACC_W-1 -: ACC_W]));
          cr_r[2]  <= VEC_W'($signed(acc_rdata[ACC_W-1:0]));
          ustart_r <= 1'b1;
          state_r  <= S_RWAIT;
        end
        S_RWAIT: begin
          if (u_rsp.done) begin
            out_valid_r              <= 1'b1;
            out_data_r.normal_vertex <= rv_r;
            out_data_r.normal_x      <= u_rsp.nx;
            out_data_r.normal_y      <= u_rsp.ny;
            out_data_r.normal_z      <= u_rsp.nz;
            out_data_r.zero_normal   <= u_rsp.zero;
            state_r                  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign u_req.start = ustart_r;
  assign u_req.vx    = cr_r[0];
  assign u_req.vy    = cr_r[1];
  assign u_req.vz    = cr_r[2];

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // vertex positions, x y z packed high to low
  vna_ram #(
    .WIDTH(POS_W),
    .DEPTH(MAX_VERTICES)
  ) u_pos_ram (
    .clk  (clk),
    .we   (pos_we),
    .waddr(pos_waddr),
    .wdata(pos_wdata),
    .raddr(pos_raddr),
    .rdata(pos_rdata)
  );

  // normal sums, x y z packed high to low
  vna_ram #(
    .WIDTH(ACC_WORD_W),
    .DEPTH(MAX_VERTICES)
  ) u_acc_ram (
    .clk  (clk),
    .we   (acc_we),
    .waddr(acc_waddr),
    .wdata(acc_wdata),
    .raddr(acc_raddr),
    .rdata(acc_rdata)
  );

  // shared unit-length scaler for face normals and reads
  vna_unit u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (u_req),
    .rsp  (u_rsp)
  );

  // a read item always makes the block busy for a while
  `VNA_ASSERT_NEXT(a_read_busy, start && !busy && in_data.operation == OP_READ, busy)
  // one result per read, never two in a row
  `VNA_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  // a zero flag comes with a zero vector
  `VNA_ASSERT_SAME(a_zero_vec, out_valid && out_data.zero_normal,
    out_data.normal_x == 0 && out_data.normal_y == 0 && out_data.normal_z == 0)
  // the scaler only answers while the sequencer waits for it
  `VNA_ASSERT_SAME(a_done_waiting, u_rsp.done, state_r == S_TWAIT || state_r == S_RWAIT)

endmodule

### src/vna_ram.sv
// generic single-write, single-read ram with registered read data
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/vna_unit.sv
// iterative unit-length scaler: normalize, sum of squares, square root, divide
module vna_unit import vna_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_NORM = 3'd1;
  localparam logic [2:0] U_SQ   = 3'd2;
  localparam logic [2:0] U_SQRT = 3'd3;
  localparam logic [2:0] U_DSET = 3'd4;
  localparam logic [2:0] U_DIV  = 3'd5;

  localparam int NM_W  = 30;
  localparam int SQ_W  = 2 * NM_W;
  localparam int RT_W  = 63;
  localparam int LEN_W = 31;
  localparam int DIV_W = 47;
  localparam int Q_W   = 16;

  logic [2:0]              state_r;
  logic [VEC_W-1:0]        mag_r [3];
  logic [2:0]              neg_r;
  logic [1:0]              cnt_r;
  logic [3:0]              step_r;
  logic [SQ_W-1:0]         sq_r;
  logic [RT_W-1:0]         sum_r;
  logic [RT_W-1:0]         root_r;
  logic [RT_W-1:0]         bit_r;
  logic [DIV_W-1:0]        rem_r;
  logic [DIV_W-1:0]        den_r;
  logic [Q_W-1:0]          q_r;
  logic signed [NRM_W-1:0] n_r [3];
  logic                    done_r;
  logic                    zero_r;

  logic [VEC_W-1:0] or_w;
  logic [VEC_W-1:0] mag_sel;
  logic [SQ_W-1:0]  sq_w;
  logic [RT_W-1:0]  try_w;
  logic             ge_w;
  logic [LEN_W-1:0] len_w;
  logic [DIV_W-1:0] num_w;
  logic             q_bit;
  logic [Q_W-1:0]   q_fin;
  logic [Q_W-1:0]   q_clip;
  logic [NRM_W-1:0] n_val;

  function automatic logic [VEC_W-1:0] vabs(input logic signed [VEC_W-1:0] v);
    return v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
  endfunction

  assign or_w    = mag_r[0] | mag_r[1] | mag_r[2];
  assign mag_sel = mag_r[cnt_r];
  assign sq_w    = mag_sel[NM_W-1:0] * mag_sel[NM_W-1:0];
  assign try_w   = root_r + bit_r;
  assign ge_w    = sum_r >= try_w;
  assign len_w   = root_r[LEN_W-1:0];
  // rounding numerator: mag * 2^14 + len / 2
  assign num_w   = DIV_W'({mag_sel[NM_W-1:0], 14'b0}) + DIV_W'(len_w >> 1);
  assign q_bit   = rem_r >= den_r;
  assign q_fin   = {q_r[Q_W-2:0], q_bit};
  assign q_clip  = (q_fin > Q_W'(ONE_Q14)) ? Q_W'(ONE_Q14) : q_fin;
  assign n_val   = neg_r[cnt_r] ? (NRM_W'(0) - NRM_W'(q_clip)) : NRM_W'(q_clip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        U_IDLE: begin
          if (req.start) begin
            mag_r[0] <= vabs(req.vx);
            mag_r[1] <= vabs(req.vy);
            mag_r[2] <= vabs(req.vz);
            neg_r    <= {req.vz[VEC_W-1], req.vy[VEC_W-1], req.vx[VEC_W-1]};
            state_r  <= U_NORM;
          end
        end
        U_NORM: begin
          if (or_w == '0) begin
            zero_r  <= 1'b1;
            n_r[0]  <= '0;
            n_r[1]  <= '0;
            n_r[2]  <= '0;
            done_r  <= 1'b1;
            state_r <= U_IDLE;
          end else if (|or_w[VEC_W-1:NM_W]) begin
            mag_r[0] <= mag_r[0] >> 1;
            mag_r[1] <= mag_r[1] >> 1;
            mag_r[2] <= mag_r[2] >> 1;
          end else if (!or_w[NM_W-1]) begin
            mag_r[0] <= mag_r[0] << 1;
            mag_r[1] <= mag_r[1] << 1;
            mag_r[2] <= mag_r[2] << 1;
          end else begin
            cnt_r   <= '0;
            sum_r   <= '0;
            state_r <= U_SQ;
          end
        end
        U_SQ: begin
          if (cnt_r != 2'd3) begin
            sq_r <= sq_w;
          end
          if (cnt_r != 2'd0) begin
            sum_r <= sum_r + RT_W'(sq_r);
          end
          if (cnt_r == 2'd3) begin
            root_r  <= '0;
            bit_r   <= RT_W'(1) << (RT_W - 1);
            state_r <= U_SQRT;
          end
          cnt_r <= cnt_r + 2'd1;
        end
        U_SQRT: begin
          if (ge_w) begin
            sum_r  <= sum_r - try_w;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == RT_W'(1)) begin
            cnt_r   <= '0;
            state_r <= U_DSET;
          end
        end
        U_DSET: begin
          rem_r   <= num_w;
          den_r   <= DIV_W'(len_w) << (Q_W - 1);
          q_r     <= '0;
          step_r  <= '0;
          state_r <= U_DIV;
        end
        U_DIV: begin
          if (q_bit) begin
            rem_r <= rem_r - den_r;
          end
          q_r    <= q_fin;
          den_r  <= den_r >> 1;
          step_r <= step_r + 4'd1;
          if (step_r == 4'd15) begin
            n_r[cnt_r] <= n_val;
            if (cnt_r == 2'd2) begin
              zero_r  <= 1'b0;
              done_r  <= 1'b1;
              state_r <= U_IDLE;
            end else begin
              cnt_r   <= cnt_r + 2'd1;
              state_r <= U_DSET;
            end
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.zero = zero_r;
  assign rsp.nx   = n_r[0];
  assign rsp.ny   = n_r[1];
  assign rsp.nz   = n_r[2];

endmodule

### sim/vna_checker.sv
// checker for the vertex normal accumulator: predicts read results and compares
module vna_checker import vna_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_count
);

  // two-state stores start at zero, as after reset
  int vert_pos [MAX_VERTICES][3];
  int normal_sum [MAX_VERTICES][3];
  out_item_t normals_due[$];

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // scale a vector to unit length in q1.14; returns 0 for a zero vector
  function automatic bit to_unit(input longint v[3], output longint n[3]);
    longint unsigned m[3], mx, sq, len, q;
    mx = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
      n[i] = 0;
    end
    if (mx == 0) return 0;
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    for (int i = 0; i < 3; i++) sq += m[i] * m[i];
    len = root_floor(sq);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * ONE_Q14 + len / 2) / len;
      if (q > ONE_Q14) q = ONE_Q14;
      n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic int sat_sum(longint acc, longint d);
    longint s;
    s = acc + d;
    if (s > (64'sd1 << 25) - 1) s = (64'sd1 << 25) - 1;
    if (s < -(64'sd1 << 25)) s = -(64'sd1 << 25);
    return int'(s);
  endfunction

  task automatic apply_item(in_item_t it);
    longint e1[3], e2[3], cr[3], n[3], v[3];
    int crn[3];
    bit ok;
    out_item_t r;
    case (it.operation)
      OP_LOAD: begin
        vert_pos[it.vertex_index][0] = int'(it.pos_x);
        vert_pos[it.vertex_index][1] = int'(it.pos_y);
        vert_pos[it.vertex_index][2] = int'(it.pos_z);
        for (int k = 0; k < 3; k++) normal_sum[it.vertex_index][k] = 0;
      end
      OP_TRI: begin
        crn[0] = int'(it.corner_a);
        crn[1] = int'(it.corner_b);
        crn[2] = int'(it.corner_c);
        for (int k = 0; k < 3; k++) begin
          e1[k] = longint'(vert_pos[crn[1]][k]) - longint'(vert_pos[crn[0]][k]);
          e2[k] = longint'(vert_pos[crn[2]][k]) - longint'(vert_pos[crn[0]][k]);
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        // degenerate face adds nothing
        if (to_unit(cr, n)) begin
          for (int c = 0; c < 3; c++)
            for (int k = 0; k < 3; k++)
              normal_sum[crn[c]][k] = sat_sum(longint'(normal_sum[crn[c]][k]), n[k]);
        end
      end
      OP_READ: begin
        for (int k = 0; k < 3; k++) v[k] = longint'(normal_sum[it.vertex_index][k]);
        ok = to_unit(v, n);
        r.normal_vertex = it.vertex_index;
        r.normal_x = NRM_W'(n[0]);
        r.normal_y = NRM_W'(n[1]);
        r.normal_z = NRM_W'(n[2]);
        r.zero_normal = !ok;
        normals_due = {normals_due, r};
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid) begin
      if (normals_due.size() == 0) begin
        report_mismatch("unexpected normal, vertex", out_data.normal_vertex, -1);
      end else begin
        w = normals_due.pop_front();
        if (out_data.normal_vertex !== w.normal_vertex)
          report_mismatch("normal_vertex", out_data.normal_vertex, w.normal_vertex);
        if (out_data.normal_x !== w.normal_x)
          report_mismatch("normal_x", out_data.normal_x, w.normal_x);
        if (out_data.normal_y !== w.normal_y)
          report_mismatch("normal_y", out_data.normal_y, w.normal_y);
        if (out_data.normal_z !== w.normal_z)
          report_mismatch("normal_z", out_data.normal_z, w.normal_z);
        if (out_data.zero_normal !== w.zero_normal)
          report_mismatch("zero_normal", out_data.zero_normal, w.zero_normal);
      end
    end
    if (rst_n && start && !busy) apply_item(in_data);
    pending_count = normals_due.size();
  end

endmodule

### sim/tb_vertex_normal_accumulator.sv
// testbench top for the vertex normal accumulator: stimulus and verdict
module tb_vertex_normal_accumulator import vna_pkg::*; ();

  logic      clk;
  logic      rst_n;
  logic      start;
  in_item_t  in_data;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;
  int        fail_count;
  int        pending_count;

  // vertices 0..31 form the working mesh that most loads use; loads and reads sometimes go to far vertices
  localparam int MESH_N = 32;
  bit loaded [MAX_VERTICES];
  int idle_pct;

  vertex_normal_accumulator u_dut (
    .clk, .rst_n, .start, .in_data, .busy, .out_valid, .out_data
  );

  vna_checker u_chk (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .fail_count, .pending_count
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #40000000;
    $display("** vertex_normal_accumulator: FAILED **");
    $finish;
  end

  // hand one item over; waits for the accept edge, then gaps at random
  task automatic send_item(in_item_t it);
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_data <= in_item_t'({$urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic in_item_t load_item(int v, int x, int y, int z);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.operation = OP_LOAD;
    it.vertex_index = IDX_W'(v);
    it.pos_x = COORD_W'(x);
    it.pos_y = COORD_W'(y);
    it.pos_z = COORD_W'(z);
    return it;
  endfunction

  function automatic in_item_t tri_item(int a, int b, int c);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.operation = OP_TRI;
    it.corner_a = IDX_W'(a);
    it.corner_b = IDX_W'(b);
    it.corner_c = IDX_W'(c);
    return it;
  endfunction

  function automatic in_item_t read_item(int v);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.operation = OP_READ;
    it.vertex_index = IDX_W'(v);
    return it;
  endfunction

  // random corner among loaded vertices
  function automatic int pick_loaded();
    int v;
    do v = $urandom_range(MAX_VERTICES - 1); while (!loaded[v]);
    return v;
  endfunction

  task automatic send_load(int v, int x, int y, int z);
    loaded[v] = 1;
    send_item(load_item(v, x, y, z));
  endtask

  // zero-sum reads before any triangle
  task automatic send_read_pair();
    send_item(read_item(0));
    send_item(read_item(4));
  endtask

  task automatic random_item();
    int r, v;
    in_item_t it;
    r = $urandom_range(99);
    if (r < 20) begin
      // sometimes full coordinate range, sometimes to a far vertex
      v = $urandom_range(9) == 0 ? $urandom_range(MAX_VERTICES - 1)
                                 : $urandom_range(MESH_N - 1);
      if ($urandom_range(3) == 0)
        send_load(v, $urandom, $urandom, $urandom);
      else
        send_load(v, $urandom_range(511) - 256, $urandom_range(511) - 256,
                  $urandom_range(511) - 256);
    end else if (r < 62) begin
      // repeated corners now and then give degenerate faces
      send_item(tri_item(pick_loaded(), pick_loaded(),
                         $urandom_range(7) == 0 ? pick_loaded() : pick_loaded()));
    end else if (r < 95) begin
      send_item(read_item($urandom_range(3) == 0 ? $urandom_range(MAX_VERTICES - 1)
                                                 : pick_loaded()));
    end else begin
      // unused operation code: no effect
      it = in_item_t'({$urandom, $urandom, $urandom});
      it.operation = OP_UNUSED;
      send_item(it);
    end
  endtask

  initial begin
    int cnt;
    rst_n = 0;
    start = 0;
    in_data = '0;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: a unit cube corner set, extremes and special cases
    send_load(0, 0, 0, 0);
    send_load(1, 256, 0, 0);
    send_load(2, 0, 256, 0);
    send_load(3, -32768, -32768, -32768);
    send_load(4, 32767, 32767, 32767);
    send_load(5, 32767, -32768, 0);
    send_read_pair();
    send_item(tri_item(0, 1, 2));
    send_item(tri_item(0, 2, 1));
    send_item(tri_item(3, 4, 5));
    send_item(tri_item(0, 0, 1));          // degenerate face
    send_item(tri_item(0, 3, 4));          // collinear corners
    send_item(read_item(0));
    send_item(read_item(1));
    send_item(read_item(5));
    send_item(read_item(1023));            // loaded-never, zero sum
    // build up one accumulator by repeating one face
    for (int i = 0; i < 8; i++) send_item(tri_item(1, 2, 0));
    send_item(read_item(2));
    send_load(2, 0, 256, 0);               // load clears the sum
    send_item(read_item(2));

    // random phases with different sender idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = ph == 0 ? 0 : ph == 1 ? 52 : ph == 2 ? 30 : 0;
      for (int i = 0; i < MESH_N; i++)
        send_load(i, $urandom_range(511) - 256, $urandom_range(511) - 256,
                  $urandom_range(511) - 256);
      for (int i = 0; i < 290; i++) random_item();
    end
    start <= 1'b0;

    cnt = 0;
    while (pending_count != 0 && cnt < 100000) begin
      @(posedge clk);
      cnt++;
    end
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("** vertex_normal_accumulator: PASSED **");
    else
      $display("** vertex_normal_accumulator: FAILED **");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/vna_pkg.sv
src/vna_ram.sv
src/vna_unit.sv
src/vertex_normal_accumulator.sv
sim/vna_checker.sv
sim/tb_vertex_normal_accumulator.sv
